>>> rtl/core/bds_pkg.sv
package bds_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned SUM_W         = CHAN_W + 1;
  localparam int unsigned MAX_CHANNELS  = 4;
  localparam int unsigned TDATA_W       = MAX_CHANNELS * CHAN_W;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned WIDTH_RESET   = 256;
  localparam int unsigned DEF_CHANNELS  = 4;
  localparam int unsigned DEF_MAX_WIDTH = 4096;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

>>> rtl/core/bds_ram.sv
module bds_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bds_lane.sv
module bds_lane (
  input  logic          clk_i,
  input  bds_pkg::chan_t left_i,
  input  bds_pkg::chan_t pix_i,
  input  logic          load_i,
  input  bds_pkg::sum_t  above_i,
  output bds_pkg::sum_t  pair_o,
  output bds_pkg::chan_t avg_o
);
  import bds_pkg::*;

  sum_t               pair_d;
  sum_t               pair_q;
  logic [SUM_W:0]     total;

  // horizontal pair sum of this channel
  assign pair_d = SUM_W'(left_i) + SUM_W'(pix_i);
  assign pair_o = pair_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_d;
    end
  end

  // block sum over the two rows, divided by four
  assign total = (SUM_W + 1)'(above_i) + (SUM_W + 1)'(pair_q);
  assign avg_o = total[SUM_W:2];

endmodule

>>> rtl/core/box_downsample_2x2.sv
// 2x2 box-filter downsampler for mipmap generation. Source pixels enter in raster order, one
// per cycle unless the output stalls, and every aligned 2x2 block yields one pixel whose
// channels are the truncated average of its four samples; a result leaves on the odd row at
// each odd column, so one output transaction follows each four input transactions on average.
// An input transaction passes the pair sum and line store read, then the block sum into the
// output register; a new one is accepted every cycle unless the output stalls. The line store
// is written per pixel pair on the even row, read on the odd row, and holds the pair sums of
// the even row (MAX_WIDTH/2 entries). The row width comes from the configuration channel, is
// clamped to 2..MAX_WIDTH and should be even; a trailing odd column or row is dropped. tlast on
// the input ends the region and restarts at row 0, column 0; tlast on the output marks the
// result caused by that pixel. Channels at or above CHANNELS read as zero.
module box_downsample_2x2 #(
  parameter int unsigned CHANNELS  = bds_pkg::DEF_CHANNELS,
  parameter int unsigned MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bds_pkg::CFG_W-1:0]   cfg_data_i,    // source_width
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bds_pkg::TDATA_W-1:0] s_axis_tdata,  // chan0, chan1, chan2, chan3
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bds_pkg::TDATA_W-1:0] m_axis_tdata,  // avg0, avg1, avg2, avg3
  output logic                        m_axis_tlast
);
  import bds_pkg::*;

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W      = (CFG_W > EW_W) ? CFG_W : EW_W;
  localparam int unsigned LINE_W     = CHANNELS * SUM_W;

  // configuration
  logic [CFG_W-1:0] width_q;
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] eff_width;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CFG_W'(WIDTH_RESET);
    end else if (cfg_valid_i) begin
      width_q <= cfg_data_i;
    end
  end

  assign width_ext = CMP_W'(width_q);

  always_comb begin
    if (width_ext < CMP_W'(2)) begin
      eff_width = CMP_W'(2);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      eff_width = CMP_W'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
  end

  // handshake and pipeline control
  logic in_acc;
  logic p1_valid_d, p1_valid_q;
  logic p1_last_q;
  logic out_free;
  logic p1_adv;
  logic out_valid_d, out_valid_q;
  logic emit;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign p1_adv        = p1_valid_q && out_free;
  assign s_axis_tready = !p1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // raster position
  logic [COL_W-1:0]  col_d, col_q;
  logic              odd_row_d, odd_row_q;
  logic              odd_col;
  logic              row_wrap;
  logic [TDATA_W-1:0] left_q;

  assign odd_col  = col_q[0];
  assign row_wrap = (CMP_W'(col_q) + CMP_W'(1)) >= eff_width;
  assign emit     = in_acc && odd_col && odd_row_q;

  always_comb begin
    col_d     = col_q;
    odd_row_d = odd_row_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        col_d     = '0;
        odd_row_d = 1'b0;
      end else if (row_wrap) begin
        col_d     = '0;
        odd_row_d = !odd_row_q;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      odd_row_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      odd_row_q <= odd_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !odd_col) begin
      left_q <= s_axis_tdata;
    end
    if (emit) begin
      p1_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    p1_valid_d = p1_valid_q;
    if (emit) begin
      p1_valid_d = 1'b1;
    end else if (p1_adv) begin
      p1_valid_d = 1'b0;
    end
  end

  // lanes: one per channel, pair sum now, block average from the registered pair sum next cycle
  logic [LINE_W-1:0]  line_wdata;
  logic [LINE_W-1:0]  line_rdata;
  logic [ADDR_W-1:0]  slot;
  logic [TDATA_W-1:0] avg_word;

  assign slot = ADDR_W'(col_q >> 1);

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      bds_lane u_lane (
        .clk_i   (clk_i),
        .left_i  (left_q[c*CHAN_W +: CHAN_W]),
        .pix_i   (s_axis_tdata[c*CHAN_W +: CHAN_W]),
        .load_i  (emit),
        .above_i (line_rdata[c*SUM_W +: SUM_W]),
        .pair_o  (line_wdata[c*SUM_W +: SUM_W]),
        .avg_o   (avg_word[c*CHAN_W +: CHAN_W])
      );
    end else begin : g_off
      assign avg_word[c*CHAN_W +: CHAN_W] = '0;
    end
  end

  bds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc && odd_col && !odd_row_q),
    .waddr_i (slot),
    .wdata_i (line_wdata),
    .re_i    (emit),
    .raddr_i (slot),
    .rdata_o (line_rdata)
  );

  // merge lanes into the output register
  logic [TDATA_W-1:0] out_data_q;
  logic               out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (p1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      out_data_q <= avg_word;
      out_last_q <= p1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> sim/box_downsample_2x2_tb.sv
module box_downsample_2x2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bds_pkg::*;

  localparam int unsigned N_CH  = DEF_CHANNELS;
  localparam int unsigned MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned COL_W = $clog2(MAX_W);

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_FIXED} exp_mode_e;

  typedef struct packed {
    logic [TDATA_W-1:0] avg;  // avg0 in the lowest byte
    logic               last;
  } block_avg_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_W-1:0]   width;
    logic [TDATA_W-1:0] pix;
    logic               fe;
    exp_mode_e          mode;
    block_avg_t         fixed;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i;     // source_width
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // chan0, chan1, chan2, chan3
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // avg0, avg1, avg2, avg3
  logic               m_axis_tlast;

  box_downsample_2x2 #(
    .CHANNELS  (N_CH),
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // mirror of the block state
  logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
  logic [COL_W-1:0] col_pos   = '0;
  logic             odd_row   = 1'b0;
  logic [31:0]      left_pix  = '0;
  logic [3:0][8:0]  pair_rows [MAX_W/2];

  block_avg_t  pending_avgs[$];
  dir_row_t    dir_tab[$];
  int unsigned mismatches = 0;
  logic        tx_idle    = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic void add_row(input dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void queue_avg(input block_avg_t a);
    pending_avgs.insert(pending_avgs.size(), a);
  endfunction

  function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
    if (w < CFG_W'(2)) return CFG_W'(2);
    if (w > CFG_W'(MAX_W)) return CFG_W'(MAX_W);
    return w;
  endfunction

  // advances the mirror by one pixel, returns 1 when a block completes
  function automatic logic box_avg_predict(input logic [31:0] pix_in, input logic fe,
                                           output block_avg_t res);
    logic [31:0]     pix;
    logic [3:0][8:0] pair;
    logic [9:0]      total;
    logic [CFG_W-1:0] eff;
    logic            hit;
    pix = '0;
    hit = 1'b0;
    res = '0;
    eff = clamp_width(width_reg);
    for (int c = 0; c < N_CH; c++) pix[8*c +: 8] = pix_in[8*c +: 8];
    if (!col_pos[0]) begin
      left_pix = pix;
    end else begin
      for (int c = 0; c < 4; c++)
        pair[c] = {1'b0, left_pix[8*c +: 8]} + {1'b0, pix[8*c +: 8]};
      if (!odd_row) begin
        pair_rows[col_pos[COL_W-1:1]] = pair;
      end else begin
        for (int c = 0; c < 4; c++) begin
          total = {1'b0, pair_rows[col_pos[COL_W-1:1]][c]} + {1'b0, pair[c]};
          if (c < N_CH) res.avg[8*c +: 8] = total[9:2];
        end
        res.last = fe;
        hit = 1'b1;
      end
    end
    if (fe) begin
      col_pos = '0;
      odd_row = 1'b0;
    end else if ({1'b0, col_pos} + CFG_W'(1) >= eff) begin
      col_pos = '0;
      odd_row = ~odd_row;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t pix_row(input logic [31:0] p, input logic fe,
                                       input exp_mode_e m, input logic [31:0] avg,
                                       input logic last);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_PIX;
    r.pix   = p;
    r.fe    = fe;
    r.mode  = m;
    r.fixed = '{avg: avg, last: last};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] w);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.width = w;
    r.mode  = EXP_NONE;
    return r;
  endfunction

  task automatic push_pixel(input logic [31:0] pix, input logic fe, input exp_mode_e mode,
                            input block_avg_t fixed);
    int unsigned gap;
    block_avg_t  res;
    logic        hit;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pix;
    s_axis_tlast  = fe;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hit = box_avg_predict(pix, fe, res);
    if (mode == EXP_FIXED) queue_avg(fixed);
    else if (mode == EXP_PREDICT && hit) queue_avg(res);
  endtask

  // block idle: every result out, and any pixel still in flight settled
  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    width_reg = w;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : result_sink
    block_avg_t  want;
    int unsigned stall;
    int unsigned seen;
    logic        rx_idle;
    m_axis_tready = 1'b0;
    seen    = 0;
    rx_idle = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      if (seen % 64 == 0) rx_idle = ($urandom_range(0, 3) != 0);
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      // long hold-off so the block fills up and back-pressures its input
      if (seen == 120) stall = 400;
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      seen++;
      if (pending_avgs.size() == 0) begin
        $error("unexpected result transaction: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_avgs.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (m_axis_tdata[8*c +: 8] !== want.avg[8*c +: 8]) begin
            $error("avg%0d mismatch: expected %0d, actual %0d", c, want.avg[8*c +: 8],
                   m_axis_tdata[8*c +: 8]);
            mismatches++;
          end
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] eff;
    int unsigned      rand_items;
    int unsigned      frames;
    int unsigned      style;
    int unsigned      len;
    logic             closing;
    logic             tail_fe;
    logic             fe;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rand_items    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // narrowest row: saturated and zero blocks
    add_row(cfg_row(CFG_W'(2)));
    add_row(pix_row('1, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('1, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('1, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('1, 1'b0, EXP_FIXED, '1, 1'b0));
    add_row(pix_row('0, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('0, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('0, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row('0, 1'b1, EXP_FIXED, '0, 1'b1));
    // width of one behaves as two; sums that truncate
    add_row(cfg_row(CFG_W'(1)));
    add_row(pix_row(32'h0103_FE01, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h0103_FF01, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h0002_FF01, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h0003_FE00, 1'b0, EXP_PREDICT, '0, 1'b0));
    // odd width, tlast on the dropped trailing column
    add_row(cfg_row(CFG_W'(3)));
    add_row(pix_row(32'h1020_3040, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h8070_6050, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'hAAAA_AAAA, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h5555_5555, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'hF00F_0FF0, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h1234_5678, 1'b1, EXP_NONE, '0, 1'b0));
    // early tlast on an even row, then mid-row on an odd row
    add_row(cfg_row(CFG_W'(4)));
    add_row(pix_row(32'hDEAD_BEEF, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'hCAFE_F00D, 1'b1, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'h0102_0304, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'hFEFD_FCFB, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h7F80_817E, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h0F1E_2D3C, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'hFFFF_0000, 1'b0, EXP_PREDICT, '0, 1'b0));
    add_row(pix_row(32'h00FF_FF00, 1'b1, EXP_PREDICT, '0, 1'b0));
    // width above capacity clamps, so a short row must not wrap
    add_row(cfg_row('1));
    add_row(pix_row(32'h0A0B_0C0D, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'hF1F2_F3F4, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'h3344_5566, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'h7788_99AA, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'hBBCC_DDEE, 1'b0, EXP_NONE, '0, 1'b0));
    add_row(pix_row(32'h1357_9BDF, 1'b1, EXP_NONE, '0, 1'b0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_outputs();
        write_width(dir_tab[i].width);
      end else begin
        push_pixel(dir_tab[i].pix, dir_tab[i].fe, dir_tab[i].mode, dir_tab[i].fixed);
      end
    end

    // each phase picks a width and ends on tlast, so the next write lands at row 0
    while (rand_items < 1200) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w = CFG_W'($urandom_range(1, 8) * 2);
        6:                w = CFG_W'($urandom_range(1, 7) * 2 + 1);
        7:                w = CFG_W'($urandom_range(0, 1));
        default:          w = CFG_W'($urandom_range(9, 32) * 2);
      endcase
      eff = clamp_width(w);
      drain_outputs();
      write_width(w);
      tx_idle = ($urandom_range(0, 3) != 0);
      frames  = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        style   = $urandom_range(0, 9);
        closing = (f == frames - 1);
        tail_fe = 1'b1;
        if (style <= 6) begin
          len     = eff * 2 * $urandom_range(1, 3);
          tail_fe = closing || ($urandom_range(0, 3) != 0);
        end else begin
          len = $urandom_range(1, eff * ((style == 9) ? 3 : 5));
        end
        for (int k = 0; k < len; k++) begin
          if (style <= 6) fe = (k == len - 1) && tail_fe;
          else if (style <= 8) fe = (k == len - 1);
          else fe = ((k == len - 1) && closing) || ($urandom_range(0, 15) == 0);
          push_pixel(rand_pixel(), fe, EXP_PREDICT, '0);
          rand_items++;
        end
      end
    end

    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
